### sv/cds_pkg.sv
// cds_pkg: shared types, constants and calendar functions of the date stepper
`default_nettype none

package cds_pkg;

  localparam int YEAR_BITS = 16;
  localparam int IN_YEAR_BITS = 16;
  // year arithmetic width: room for a sum of two years plus the zero skip
  localparam int AW = ((YEAR_BITS > IN_YEAR_BITS) ? YEAR_BITS : IN_YEAR_BITS) + 2;
  localparam longint YMAX = (longint'(1) << (YEAR_BITS - 1)) - longint'(1);
  localparam logic signed [YEAR_BITS-1:0] START_YEAR = YEAR_BITS'(2001);

  localparam logic [3:0] MONTH_JAN = 4'd1;
  localparam logic [3:0] MONTH_FEB = 4'd2;
  localparam logic [3:0] MONTH_MAR = 4'd3;
  localparam logic [3:0] MONTH_DEC = 4'd12;
  localparam logic [4:0] DAY_FIRST = 5'd1;
  localparam logic [4:0] DAY_FEB_COMMON = 5'd28;
  localparam logic [4:0] DAY_FEB_LEAP = 5'd29;
  localparam logic [4:0] DAY_DEC_LAST = 5'd31;

  // multiplicative inverse of 25 modulo 2^32 and the divisibility limit
  localparam logic [31:0] INV25 = 32'hC28F5C29;
  localparam logic [31:0] DIV25_LIMIT = 32'h0A3D70A3;

  localparam logic [4:0] MONTH_LEN [1:12] = '{
    5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
    5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
  };

  typedef enum logic [2:0] {
    OP_LOAD       = 3'd0,
    OP_NEXT_DAY   = 3'd1,
    OP_PREV_DAY   = 3'd2,
    OP_NEXT_MONTH = 3'd3,
    OP_PREV_MONTH = 3'd4,
    OP_NEXT_YEAR  = 3'd5,
    OP_PREV_YEAR  = 3'd6,
    OP_ADD_YEARS  = 3'd7
  } op_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_BAD_LOAD = 2'd1,
    ST_YEAR_OVF = 2'd2
  } status_t;

  typedef struct packed {
    op_t                            opcode;
    logic signed [IN_YEAR_BITS-1:0] load_year;
    logic [3:0]                     load_month;
    logic [4:0]                     load_day;
    logic signed [IN_YEAR_BITS-1:0] years_delta;
  } cmd_t;

  typedef struct packed {
    logic signed [YEAR_BITS-1:0] year;
    logic [3:0]                  month;
    logic [4:0]                  day;
    logic                        leap;
    status_t                     status;
  } res_t;

  // years before 1 are shifted up by one before the usual rule
  function automatic logic leap_of(input logic signed [YEAR_BITS-1:0] y);
    logic signed [YEAR_BITS-1:0] t;
    logic [31:0] a;
    logic [31:0] prod;
    logic by4;
    logic by16;
    logic by25;
    t = y[YEAR_BITS-1] ? (y + {{(YEAR_BITS-1){1'b0}}, 1'b1}) : y;
    a = 32'(t[YEAR_BITS-1] ? -t : t);
    prod = a * INV25;
    by4 = (t[1:0] == 2'b00);
    by16 = (t[3:0] == 4'b0000);
    by25 = (prod <= DIV25_LIMIT);
    return by4 && (!by25 || by16);
  endfunction

  function automatic logic [4:0] days_in(input logic [3:0] m, input logic leap);
    logic [4:0] len;
    len = 5'd0;
    if (m == MONTH_FEB) begin
      len = leap ? DAY_FEB_LEAP : DAY_FEB_COMMON;
    end else if (m >= MONTH_JAN && m <= MONTH_DEC) begin
      len = MONTH_LEN[m];
    end
    return len;
  endfunction

endpackage

`default_nettype wire

### sv/cds_if.sv
// cds_if: command and result channel interfaces of the date stepper
`default_nettype none

interface cds_cmd_if import cds_pkg::*; ();
  logic                           valid;
  logic                           ready;
  logic [2:0]                     opcode;
  logic signed [IN_YEAR_BITS-1:0] load_year;
  logic [3:0]                     load_month;
  logic [4:0]                     load_day;
  logic signed [IN_YEAR_BITS-1:0] years_delta;

  modport source (
    output valid, opcode, load_year, load_month, load_day, years_delta,
    input  ready
  );
  modport sink (
    input  valid, opcode, load_year, load_month, load_day, years_delta,
    output ready
  );
endinterface

interface cds_res_if import cds_pkg::*; ();
  logic                        valid;
  logic                        ready;
  logic signed [YEAR_BITS-1:0] cur_year;
  logic [3:0]                  cur_month;
  logic [4:0]                  cur_day;
  logic                        is_leap;
  logic [1:0]                  status;

  modport source (
    output valid, cur_year, cur_month, cur_day, is_leap, status,
    input  ready
  );
  modport sink (
    input  valid, cur_year, cur_month, cur_day, is_leap, status,
    output ready
  );
endinterface

`default_nettype wire

### sv/calendar_date_stepper.sv
// a command passes through the input register and then the result register before its result is offered on res
// one command per cycle while res.ready is high; the date update is a single combinational pass
// while a result waits, one more command fills the input register, then cmd.ready drops
// rst (synchronous, active high) sets the date to 1 January 2001 and empties both stages
// the date registers change only on a command with status ok
`default_nettype none

module calendar_date_stepper import cds_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  cds_cmd_if.sink   cmd,
  cds_res_if.source res
);

  cmd_t item;
  logic item_valid;
  logic advance;
  res_t result;

  cds_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .advance    (advance),
    .item       (item),
    .item_valid (item_valid)
  );

  cds_core u_core (
    .clk    (clk),
    .rst    (rst),
    .item   (item),
    .fire   (advance),
    .result (result)
  );

  cds_out_stage u_out (
    .clk        (clk),
    .rst        (rst),
    .result     (result),
    .item_valid (item_valid),
    .advance    (advance),
    .res        (res)
  );

endmodule

`default_nettype wire

### sv/cds_in_stage.sv
// cds_in_stage: input register that captures one command transaction
`default_nettype none

module cds_in_stage import cds_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  cds_cmd_if.sink    cmd,
  input  logic       advance,
  output cmd_t       item,
  output logic       item_valid
);

  assign cmd.ready = !item_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (cmd.ready) begin
      item_valid <= cmd.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.valid && cmd.ready) begin
      item.opcode      <= op_t'(cmd.opcode);
      item.load_year   <= cmd.load_year;
      item.load_month  <= cmd.load_month;
      item.load_day    <= cmd.load_day;
      item.years_delta <= cmd.years_delta;
    end
  end

endmodule

`default_nettype wire

### sv/cds_core.sv
// cds_core: date state registers and the single-pass update logic
`default_nettype none

module cds_core import cds_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  cmd_t item,
  input  logic fire,
  output res_t result
);

  localparam logic signed [AW-1:0] YMAX_W = AW'(YMAX);

  logic signed [YEAR_BITS-1:0] year_reg;
  logic [3:0]                  month_reg;
  logic [4:0]                  day_reg;
  logic                        leap_reg;

  always_comb begin
    logic signed [AW-1:0] y_w;
    logic signed [AW-1:0] addend;
    logic signed [AW-1:0] sum;
    logic signed [AW-1:0] cand;
    logic                 in_range;
    logic                 leap_new;
    logic [4:0]           len_cur;
    logic [3:0]           m_inc;
    logic [3:0]           m_dec;
    logic [4:0]           len_inc;
    logic [4:0]           len_dec;
    logic [4:0]           len_load;
    logic                 feb29;
    logic [3:0]           m_n;
    logic [4:0]           d_n;
    status_t              st;
    logic                 commit;

    y_w = AW'(year_reg);
    len_cur = days_in(month_reg, leap_reg);
    m_inc = (month_reg == MONTH_DEC) ? MONTH_JAN : month_reg + 4'd1;
    m_dec = (month_reg == MONTH_JAN) ? MONTH_DEC : month_reg - 4'd1;
    len_inc = days_in(m_inc, leap_reg);
    len_dec = days_in(m_dec, leap_reg);
    feb29 = (month_reg == MONTH_FEB) && (day_reg == DAY_FEB_LEAP);

    // year change that this command asks for
    addend = '0;
    case (item.opcode)
      OP_NEXT_DAY: begin
        if (day_reg >= len_cur && month_reg == MONTH_DEC) addend = AW'(1);
      end
      OP_PREV_DAY: begin
        if (day_reg == DAY_FIRST && month_reg == MONTH_JAN) addend = -AW'(1);
      end
      OP_NEXT_MONTH: begin
        if (month_reg == MONTH_DEC) addend = AW'(1);
      end
      OP_PREV_MONTH: begin
        if (month_reg == MONTH_JAN) addend = -AW'(1);
      end
      OP_NEXT_YEAR:  addend = AW'(1);
      OP_PREV_YEAR:  addend = -AW'(1);
      OP_ADD_YEARS:  addend = AW'(item.years_delta);
      default:       addend = '0;
    endcase

    // there is no year zero: crossing it costs one more step
    sum = y_w + addend;
    if (y_w < 0 && sum >= 0) begin
      sum = sum + AW'(1);
    end else if (y_w > 0 && sum <= 0) begin
      sum = sum - AW'(1);
    end
    cand = (item.opcode == OP_LOAD) ? AW'(item.load_year) : sum;
    in_range = (cand <= YMAX_W) && (cand >= -YMAX_W) && (cand != '0);
    leap_new = leap_of(cand[YEAR_BITS-1:0]);
    len_load = days_in(item.load_month, leap_new);

    m_n = month_reg;
    d_n = day_reg;
    st = ST_OK;
    case (item.opcode)
      OP_LOAD: begin
        m_n = item.load_month;
        d_n = item.load_day;
        if (!in_range || len_load == 5'd0 || item.load_day == 5'd0 ||
            item.load_day > len_load) begin
          st = ST_BAD_LOAD;
        end
      end
      OP_NEXT_DAY: begin
        if (day_reg < len_cur) begin
          d_n = day_reg + 5'd1;
        end else begin
          d_n = DAY_FIRST;
          m_n = m_inc;
        end
      end
      OP_PREV_DAY: begin
        if (day_reg > DAY_FIRST) begin
          d_n = day_reg - 5'd1;
        end else begin
          m_n = m_dec;
          d_n = (month_reg == MONTH_JAN) ? DAY_DEC_LAST : len_dec;
        end
      end
      OP_NEXT_MONTH: begin
        m_n = m_inc;
        d_n = (day_reg > len_inc) ? len_inc : day_reg;
      end
      OP_PREV_MONTH: begin
        m_n = m_dec;
        d_n = (day_reg > len_dec) ? len_dec : day_reg;
      end
      OP_NEXT_YEAR: begin
        if (feb29) begin
          m_n = MONTH_MAR;
          d_n = DAY_FIRST;
        end
      end
      OP_PREV_YEAR: begin
        if (feb29) d_n = DAY_FEB_COMMON;
      end
      OP_ADD_YEARS: begin
        if (feb29 && !leap_new) begin
          m_n = MONTH_MAR;
          d_n = DAY_FIRST;
        end
      end
      default: begin
        m_n = month_reg;
        d_n = day_reg;
      end
    endcase
    if (item.opcode != OP_LOAD && !in_range) st = ST_YEAR_OVF;

    commit = (st == ST_OK);
    result.year   = commit ? cand[YEAR_BITS-1:0] : year_reg;
    result.month  = commit ? m_n : month_reg;
    result.day    = commit ? d_n : day_reg;
    result.leap   = commit ? leap_new : leap_reg;
    result.status = st;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      year_reg  <= START_YEAR;
      month_reg <= MONTH_JAN;
      day_reg   <= DAY_FIRST;
      leap_reg  <= leap_of(START_YEAR);
    end else if (fire) begin
      year_reg  <= result.year;
      month_reg <= result.month;
      day_reg   <= result.day;
      leap_reg  <= result.leap;
    end
  end

endmodule

`default_nettype wire

### sv/cds_out_stage.sv
// cds_out_stage: result register feeding the result channel
`default_nettype none

module cds_out_stage import cds_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  res_t      result,
  input  logic      item_valid,
  output logic      advance,
  cds_res_if.source res
);

  res_t out_q;

  // the pending command moves on when the result register is free or draining
  assign advance = item_valid && (!res.valid || res.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
    end else if (advance) begin
      res.valid <= 1'b1;
    end else if (res.ready) begin
      res.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_q <= result;
    end
  end

  assign res.cur_year  = out_q.year;
  assign res.cur_month = out_q.month;
  assign res.cur_day   = out_q.day;
  assign res.is_leap   = out_q.leap;
  assign res.status    = out_q.status;

endmodule

`default_nettype wire
